>>> rtl/core/fst_pkg.sv
package fst_pkg;

  localparam int NUM_ENTRIES = 16;
  localparam int IDX_W       = $clog2(NUM_ENTRIES);
  localparam int ACC_W       = $clog2(NUM_ENTRIES + 1);

  localparam logic [1:0] LVL_OK      = 2'd0;
  localparam logic [1:0] LVL_WARNING = 2'd2;
  localparam logic [1:0] LVL_ERROR   = 2'd3;

  typedef enum logic [1:0] {
    ACT_SET  = 2'd0,
    ACT_UP   = 2'd1,
    ACT_DOWN = 2'd2
  } fst_action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_WSTART,
    S_WCHK,
    S_RSTART,
    S_RCNT,
    S_DONE
  } fst_state_t;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] entry_index;
    logic [1:0] new_level;
  } fst_in_t;

  typedef struct packed {
    logic [1:0] previous_level;
    logic       level_changed;
    logic [3:0] shown_entry;
    logic       all_ok_shown;
    logic [4:0] not_ok_count;
    logic       warning_lamp;
    logic       error_lamp;
  } fst_out_t;

  function automatic logic [4:0] sat_count(input logic [ACC_W-1:0] n);
    logic [ACC_W+4:0] wide;
    wide = {5'd0, n};
    if (wide > (ACC_W + 5)'(31)) begin
      return 5'd31;
    end
    return wide[4:0];
  endfunction

  function automatic logic [3:0] low_index(input logic [IDX_W-1:0] c);
    logic [IDX_W+3:0] wide;
    wide = {4'd0, c};
    return wide[3:0];
  endfunction

endpackage

>>> rtl/core/fault_status_table.sv
// Alarm level table with display cursor and warning/error lamps. Each input word
// (set a level, scroll up, scroll down) yields one result word. Levels live in a
// synchronous RAM with registered read; reset takes effect at once through per-entry
// valid bits. Run time is set by the RAM scan: a scroll walks from the cursor until it
// meets a non-ok entry or the table's end, a set to a non-ok level runs a full recount,
// and a set that clears an entry runs two scroll walks and a full recount. One word is
// in work at a time; the result register lets the next word in while a result waits
// to be taken.
module fault_status_table (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  fst_pkg::fst_in_t   in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output fst_pkg::fst_out_t  out_word
);
  import fst_pkg::*;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_ENTRIES - 1);

  fst_state_t state, state_next;

  logic [1:0]       mem [NUM_ENTRIES];
  logic [1:0]       rdata;
  logic             rvld;
  logic [NUM_ENTRIES-1:0] vld;
  logic             mem_we;
  logic [1:0]       lvl_rd;

  logic [IDX_W-1:0] ptr, ptr_next;
  logic [1:0]       act;
  logic [IDX_W-1:0] idx_addr;
  logic             idx_ok;
  logic [1:0]       lvl_q;
  logic [1:0]       prev, prev_next;
  logic             changed, changed_next;
  logic [IDX_W-1:0] cursor, cursor_next;
  logic             all_ok, all_ok_next;
  logic [4:0]       bad_count, bad_count_next;
  logic             warn, warn_next;
  logic             err, err_next;
  logic [ACC_W-1:0] acc, acc_next, acc_sum;
  logic             acc_w, acc_w_next;
  logic             acc_e, acc_e_next;
  logic             clear_walk, clear_walk_next;
  logic             dir_down, dir_down_next;

  logic [IDX_W+3:0] in_ext;
  logic             in_ok;
  logic [IDX_W-1:0] in_addr;
  logic [1:0]       look_prev;
  logic             look_changed;
  logic             cur_edge, ptr_edge;
  logic             walk_end;
  fst_state_t       walk_exit;
  logic             out_free;

  assign in_ext   = {4'd0, in_word.entry_index};
  assign in_ok    = in_ext < (IDX_W + 4)'(NUM_ENTRIES);
  assign in_addr  = in_ok ? in_ext[IDX_W-1:0] : '0;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  assign lvl_rd       = rvld ? rdata : LVL_OK;
  assign look_prev    = idx_ok ? lvl_rd : LVL_OK;
  assign look_changed = (act == ACT_SET) && idx_ok && (look_prev != lvl_q);

  assign cur_edge = dir_down ? (cursor == '0) : (cursor == LAST);
  assign ptr_edge = dir_down ? (ptr == '0) : (ptr == LAST);
  assign walk_end = ((state == S_WSTART) && ((bad_count == 5'd0) || cur_edge)) ||
                    ((state == S_WCHK) && ((lvl_rd != LVL_OK) || ptr_edge));
  assign walk_exit = clear_walk ? (dir_down ? S_RSTART : S_WSTART) : S_DONE;

  assign acc_sum = acc + ACC_W'((lvl_rd == LVL_WARNING) || (lvl_rd == LVL_ERROR));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_LOOK;
      end
      S_LOOK: begin
        if (look_changed) begin
          state_next = (lvl_q != LVL_OK) ? S_RSTART : S_WSTART;
        end else if (act == ACT_UP || act == ACT_DOWN) begin
          state_next = S_WSTART;
        end else begin
          state_next = S_DONE;
        end
      end
      S_WSTART: begin
        state_next = walk_end ? walk_exit : S_WCHK;
      end
      S_WCHK: begin
        state_next = walk_end ? walk_exit : S_WCHK;
      end
      S_RSTART: state_next = S_RCNT;
      S_RCNT: begin
        if (ptr == LAST) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ptr_next        = ptr;
    prev_next       = prev;
    changed_next    = changed;
    cursor_next     = cursor;
    all_ok_next     = all_ok;
    bad_count_next  = bad_count;
    warn_next       = warn;
    err_next        = err;
    acc_next        = acc;
    acc_w_next      = acc_w;
    acc_e_next      = acc_e;
    clear_walk_next = clear_walk;
    dir_down_next   = dir_down;
    mem_we          = 1'b0;
    unique case (state)
      S_IDLE: begin
        ptr_next = in_addr;
      end
      S_LOOK: begin
        prev_next       = look_prev;
        changed_next    = look_changed;
        clear_walk_next = 1'b0;
        dir_down_next   = (act == ACT_DOWN);
        if (look_changed) begin
          mem_we        = 1'b1;
          dir_down_next = 1'b0;
          if (lvl_q != LVL_OK) begin
            cursor_next = idx_addr;
            all_ok_next = 1'b0;
          end else begin
            clear_walk_next = 1'b1;
          end
        end
      end
      S_WSTART: begin
        if (bad_count == 5'd0) begin
          all_ok_next = 1'b1;
        end else if (!cur_edge) begin
          ptr_next = dir_down ? cursor - 1'b1 : cursor + 1'b1;
        end
      end
      S_WCHK: begin
        if (lvl_rd != LVL_OK) begin
          cursor_next = ptr;
          all_ok_next = 1'b0;
        end else if (!ptr_edge) begin
          ptr_next = dir_down ? ptr - 1'b1 : ptr + 1'b1;
        end
      end
      S_RSTART: begin
        ptr_next   = '0;
        acc_next   = '0;
        acc_w_next = 1'b0;
        acc_e_next = 1'b0;
      end
      S_RCNT: begin
        acc_next   = acc_sum;
        acc_w_next = acc_w || (lvl_rd == LVL_WARNING);
        acc_e_next = acc_e || (lvl_rd == LVL_ERROR);
        if (ptr == LAST) begin
          bad_count_next = sat_count(acc_sum);
          warn_next      = acc_w_next;
          err_next       = acc_e_next;
          if (sat_count(acc_sum) == 5'd0) all_ok_next = 1'b1;
        end else begin
          ptr_next = ptr + 1'b1;
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
    if (walk_end && clear_walk && !dir_down) dir_down_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[idx_addr] <= lvl_q;
    rdata <= mem[ptr_next];
    rvld  <= vld[ptr_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (mem_we) begin
      vld[idx_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      act      <= in_word.action;
      idx_addr <= in_addr;
      idx_ok   <= in_ok;
      lvl_q    <= in_word.new_level;
    end
    ptr        <= ptr_next;
    prev       <= prev_next;
    changed    <= changed_next;
    acc        <= acc_next;
    acc_w      <= acc_w_next;
    acc_e      <= acc_e_next;
    clear_walk <= clear_walk_next;
    dir_down   <= dir_down_next;
    if (state == S_DONE && out_free) begin
      out_word.previous_level <= prev;
      out_word.level_changed  <= changed;
      out_word.shown_entry    <= low_index(cursor);
      out_word.all_ok_shown   <= all_ok;
      out_word.not_ok_count   <= bad_count;
      out_word.warning_lamp   <= warn;
      out_word.error_lamp     <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cursor    <= '0;
      all_ok    <= 1'b1;
      bad_count <= 5'd0;
      warn      <= 1'b0;
      err       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cursor    <= cursor_next;
      all_ok    <= all_ok_next;
      bad_count <= bad_count_next;
      warn      <= warn_next;
      err       <= err_next;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_look: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == S_LOOK)
    else $error("accepted word did not start a lookup");

  a_idle_zero_allok: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && bad_count == 5'd0 |-> all_ok)
    else $error("zero count without all-ok display");

  a_lamps_count: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> ((warn || err) == (bad_count != 5'd0)))
    else $error("lamps disagree with count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    bad_count <= sat_count(ACC_W'(NUM_ENTRIES)))
    else $error("count above table size");

  a_write_only_look: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> state == S_RSTART || state == S_WSTART)
    else $error("table write not followed by walk or recount");

endmodule
